// File: rtl/spc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Shared constants and stage types for the skin pixel classifier.
// ----------------------------------------------------------------------------
package spc_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_HUE_LOW  = 3'd0;
	localparam logic [2:0] REG_HUE_HIGH = 3'd1;
	localparam logic [2:0] REG_CB_LOWER = 3'd2;
	localparam logic [2:0] REG_CB_UPPER = 3'd3;
	localparam logic [2:0] REG_CR_LOWER = 3'd4;
	localparam logic [2:0] REG_CR_UPPER = 3'd5;
	localparam logic [2:0] REG_LUMA_MIN = 3'd6;

	// Register reset values, in the units the registers are written in.
	localparam int HUE_LOW_RESET  = 60;
	localparam int HUE_HIGH_RESET = 200;
	localparam int CB_LOWER_RESET = -70;
	localparam int CB_UPPER_RESET = -15;
	localparam int CR_LOWER_RESET = 10;
	localparam int CR_UPPER_RESET = 30;
	localparam int LUMA_MIN_RESET = 100;

	// Color conversion works on sums scaled by this factor.
	localparam int LIMIT_SCALE = 1000;

	localparam int COEF_Y_R  = 299;
	localparam int COEF_Y_G  = 587;
	localparam int COEF_Y_B  = 114;
	localparam int COEF_CB_R = 172;
	localparam int COEF_CB_G = 399;
	localparam int COEF_CB_B = 511;
	localparam int COEF_CR_R = 511;
	localparam int COEF_CR_G = 428;
	localparam int COEF_CR_B = 83;

	localparam int HUE_STEP       = 60;
	localparam int HUE_GREEN_BASE = 120;
	localparam int HUE_BLUE_BASE  = 240;
	localparam int HUE_FULL       = 360;

	localparam logic [7:0] WHITE_LEVEL = 8'd255;

	// Which channel holds the maximum.
	localparam logic [1:0] SECTOR_RED   = 2'd0;
	localparam logic [1:0] SECTOR_GREEN = 2'd1;
	localparam logic [1:0] SECTOR_BLUE  = 2'd2;

	typedef struct packed {
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [17:0]        luma;
		logic signed [18:0] cb;
		logic signed [18:0] cr;
		logic [1:0]         sector;
		logic               gray;
		logic               neg;
		logic [7:0]         diff_mag;
		logic [7:0]         span;
	} front_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        color_ok;
		logic [1:0]  sector;
		logic        gray;
		logic        neg;
		logic [13:0] rem;
		logic [7:0]  span;
		logic [5:0]  quo;
	} div_t;

endpackage

// File: rtl/spc_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_color
// First stage logic: scaled YCbCr sums, max/min search and hue numerator sign.
// ----------------------------------------------------------------------------
module spc_color (
	input  logic [7:0]      red,
	input  logic [7:0]      green,
	input  logic [7:0]      blue,
	output spc_pkg::front_t front
);

	logic [7:0]         mx;
	logic [7:0]         mn;
	logic [1:0]         sector;
	logic signed [8:0]  diff;
	logic signed [8:0]  diff_neg;
	logic signed [18:0] r19;
	logic signed [18:0] g19;
	logic signed [18:0] b19;

	assign r19 = $signed({11'd0, red});
	assign g19 = $signed({11'd0, green});
	assign b19 = $signed({11'd0, blue});

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;

		// Ties resolve to red first, then green.
		if (mx == red) begin
			sector = spc_pkg::SECTOR_RED;
		end else if (mx == green) begin
			sector = spc_pkg::SECTOR_GREEN;
		end else begin
			sector = spc_pkg::SECTOR_BLUE;
		end

		case (sector)
			spc_pkg::SECTOR_RED: begin
				diff = $signed({1'b0, green}) - $signed({1'b0, blue});
			end
			spc_pkg::SECTOR_GREEN: begin
				diff = $signed({1'b0, blue}) - $signed({1'b0, red});
			end
			spc_pkg::SECTOR_BLUE: begin
				diff = $signed({1'b0, red}) - $signed({1'b0, green});
			end
			default: begin
				diff = 9'sd0;
			end
		endcase
		diff_neg = -diff;
	end

	always_comb begin
		front.red      = red;
		front.green    = green;
		front.blue     = blue;
		front.luma     = {10'd0, red} * 18'(spc_pkg::COEF_Y_R)
			+ {10'd0, green} * 18'(spc_pkg::COEF_Y_G)
			+ {10'd0, blue} * 18'(spc_pkg::COEF_Y_B);
		front.cb       = b19 * 19'(spc_pkg::COEF_CB_B)
			- r19 * 19'(spc_pkg::COEF_CB_R)
			- g19 * 19'(spc_pkg::COEF_CB_G);
		front.cr       = r19 * 19'(spc_pkg::COEF_CR_R)
			- g19 * 19'(spc_pkg::COEF_CR_G)
			- b19 * 19'(spc_pkg::COEF_CR_B);
		front.sector   = sector;
		front.gray     = (mx == mn);
		front.neg      = diff[8];
		front.diff_mag = diff[8] ? diff_neg[7:0] : diff[7:0];
		front.span     = mx - mn;
	end

endmodule

// File: rtl/spc_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_div_step
// Three restoring division steps of the hue quotient.
// ----------------------------------------------------------------------------
module spc_div_step (
	input  logic [13:0] rem_in,
	input  logic [10:0] den,
	output logic [13:0] rem_out,
	output logic [2:0]  quo_bits
);

	logic [14:0] trial;
	logic [13:0] rem;

	// The caller passes the divisor already shifted to this stage's bit weight.
	always_comb begin
		rem = rem_in;
		quo_bits = 3'd0;
		for (int i = 2; i >= 0; i--) begin
			trial = {1'b0, rem} - ({4'd0, den} << i);
			if (!trial[14]) begin
				rem = trial[13:0];
				quo_bits[i] = 1'b1;
			end
		end
		rem_out = rem;
	end

endmodule

// File: rtl/spc_hue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_hue
// Final hue assembly: quotient sign, sector offset, wrap into 0..359, limits.
// ----------------------------------------------------------------------------
module spc_hue (
	input  spc_pkg::div_t item,
	input  logic [8:0]    hue_low,
	input  logic [8:0]    hue_high,
	output logic          hue_ok
);

	logic signed [9:0] quo_s;
	logic signed [9:0] base;
	logic signed [9:0] raw;
	logic signed [9:0] wrapped;
	logic [8:0]        hue;

	always_comb begin
		quo_s = item.neg ? -$signed({4'd0, item.quo}) : $signed({4'd0, item.quo});
		case (item.sector)
			spc_pkg::SECTOR_RED:   base = 10'sd0;
			spc_pkg::SECTOR_GREEN: base = 10'(spc_pkg::HUE_GREEN_BASE);
			spc_pkg::SECTOR_BLUE:  base = 10'(spc_pkg::HUE_BLUE_BASE);
			default:               base = 10'sd0;
		endcase
		raw = base + quo_s;
		// Only the red sector can go negative; it folds back into range.
		wrapped = raw[9] ? raw + 10'(spc_pkg::HUE_FULL) : raw;
		hue = item.gray ? 9'd0 : wrapped[8:0];
		hue_ok = (hue < hue_low) || (hue > hue_high);
	end

endmodule

// File: rtl/skin_pixel_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skin_pixel_classifier_unit
// Per-pixel skin test on YCbCr limits and hue; non-skin pixels turn white.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  pixel    | pixel_valid / pixel_stall  | pixel_red, pixel_green, pixel_blue
//  result   | result_valid / result_stall| out_red, out_green, out_blue, is_skin
//  config   | cfg_we                     | cfg_index, cfg_data
//
// One pixel is taken per clock while pixel_stall is low. Each result passes
// through five register stages, in order: conversion, limit compare, two
// division stages of three quotient bits each, and hue decision. The first
// stage loads at the transfer itself.
// Reset clears every valid bit and loads the default limits.
// A stalled result holds; empty stages still fill behind it, and the input
// stalls only once the stage in front of it is full and cannot move.
// ----------------------------------------------------------------------------
module skin_pixel_classifier_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_valid,
	output logic       pixel_stall,
	input  logic [7:0] pixel_red,
	input  logic [7:0] pixel_green,
	input  logic [7:0] pixel_blue,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic       is_skin,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data
);

	// Color limits are held pre-scaled to match the conversion sums; hue limits are not.
	logic [8:0]         hue_low_q;
	logic [8:0]         hue_high_q;
	logic signed [18:0] cb_lower_q;
	logic signed [18:0] cb_upper_q;
	logic signed [18:0] cr_lower_q;
	logic signed [18:0] cr_upper_q;
	logic [17:0]        luma_min_q;

	logic signed [18:0] cfg_signed;
	logic signed [18:0] cfg_scaled;
	logic [17:0]        cfg_luma;

	spc_pkg::front_t front;
	spc_pkg::front_t stage_s1;
	spc_pkg::div_t   mid;
	spc_pkg::div_t   stage_s2;
	spc_pkg::div_t   stage_s3;
	spc_pkg::div_t   stage_s4;
	spc_pkg::div_t   next_s3;
	spc_pkg::div_t   next_s4;
	logic            valid_s1;
	logic            valid_s2;
	logic            valid_s3;
	logic            valid_s4;

	logic            en_s1;
	logic            en_s2;
	logic            en_s3;
	logic            en_s4;
	logic            en_out;

	logic [13:0] rem_a;
	logic [2:0]  bits_a;
	logic [13:0] rem_b;
	logic [2:0]  bits_b;
	logic        hue_ok;
	logic        skin;

	// Configuration registers.
	assign cfg_signed = {{10{cfg_data[8]}}, cfg_data};
	assign cfg_scaled = cfg_signed * 19'(spc_pkg::LIMIT_SCALE);
	assign cfg_luma   = {10'd0, cfg_data[7:0]} * 18'(spc_pkg::LIMIT_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_q  <= 9'(spc_pkg::HUE_LOW_RESET);
			hue_high_q <= 9'(spc_pkg::HUE_HIGH_RESET);
			cb_lower_q <= 19'(spc_pkg::CB_LOWER_RESET * spc_pkg::LIMIT_SCALE);
			cb_upper_q <= 19'(spc_pkg::CB_UPPER_RESET * spc_pkg::LIMIT_SCALE);
			cr_lower_q <= 19'(spc_pkg::CR_LOWER_RESET * spc_pkg::LIMIT_SCALE);
			cr_upper_q <= 19'(spc_pkg::CR_UPPER_RESET * spc_pkg::LIMIT_SCALE);
			luma_min_q <= 18'(spc_pkg::LUMA_MIN_RESET * spc_pkg::LIMIT_SCALE);
		end else if (cfg_we) begin
			case (cfg_index)
				spc_pkg::REG_HUE_LOW:  hue_low_q  <= cfg_data;
				spc_pkg::REG_HUE_HIGH: hue_high_q <= cfg_data;
				spc_pkg::REG_CB_LOWER: cb_lower_q <= cfg_scaled;
				spc_pkg::REG_CB_UPPER: cb_upper_q <= cfg_scaled;
				spc_pkg::REG_CR_LOWER: cr_lower_q <= cfg_scaled;
				spc_pkg::REG_CR_UPPER: cr_upper_q <= cfg_scaled;
				spc_pkg::REG_LUMA_MIN: luma_min_q <= cfg_luma;
				default: begin
				end
			endcase
		end
	end

	// A stage loads when it is empty or its content moves on.
	assign en_out      = !result_valid || !result_stall;
	assign en_s4       = !valid_s4 || en_out;
	assign en_s3       = !valid_s3 || en_s4;
	assign en_s2       = !valid_s2 || en_s3;
	assign en_s1       = !valid_s1 || en_s2;
	assign pixel_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= pixel_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_out) result_valid <= valid_s4;
		end
	end

	spc_color u_color (
		.red   (pixel_red),
		.green (pixel_green),
		.blue  (pixel_blue),
		.front (front)
	);

	// Stage two: limit compares and the scaled hue numerator.
	always_comb begin
		mid.red      = stage_s1.red;
		mid.green    = stage_s1.green;
		mid.blue     = stage_s1.blue;
		mid.color_ok = (stage_s1.luma > luma_min_q)
			&& (stage_s1.cb > cb_lower_q) && (stage_s1.cb < cb_upper_q)
			&& (stage_s1.cr > cr_lower_q) && (stage_s1.cr < cr_upper_q);
		mid.sector   = stage_s1.sector;
		mid.gray     = stage_s1.gray;
		mid.neg      = stage_s1.neg;
		mid.rem      = {6'd0, stage_s1.diff_mag} * 14'(spc_pkg::HUE_STEP);
		mid.span     = stage_s1.span;
		mid.quo      = 6'd0;
	end

	spc_div_step u_div_hi (
		.rem_in   (stage_s2.rem),
		.den      ({stage_s2.span, 3'b000}),
		.rem_out  (rem_a),
		.quo_bits (bits_a)
	);

	spc_div_step u_div_lo (
		.rem_in   (stage_s3.rem),
		.den      ({3'd0, stage_s3.span}),
		.rem_out  (rem_b),
		.quo_bits (bits_b)
	);

	// Division stages pass the item on with the new remainder and quotient bits.
	always_comb begin
		next_s3     = stage_s2;
		next_s3.rem = rem_a;
		next_s3.quo = {bits_a, 3'b000};
		next_s4     = stage_s3;
		next_s4.rem = rem_b;
		next_s4.quo = {stage_s3.quo[5:3], bits_b};
	end

	spc_hue u_hue (
		.item     (stage_s4),
		.hue_low  (hue_low_q),
		.hue_high (hue_high_q),
		.hue_ok   (hue_ok)
	);

	assign skin = hue_ok && stage_s4.color_ok;

	always_ff @(posedge clk) begin
		if (en_s1) stage_s1 <= front;
		if (en_s2) stage_s2 <= mid;
		if (en_s3) stage_s3 <= next_s3;
		if (en_s4) stage_s4 <= next_s4;
		if (en_out) begin
			out_red   <= skin ? stage_s4.red : spc_pkg::WHITE_LEVEL;
			out_green <= skin ? stage_s4.green : spc_pkg::WHITE_LEVEL;
			out_blue  <= skin ? stage_s4.blue : spc_pkg::WHITE_LEVEL;
			is_skin   <= skin;
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for skin_pixel_classifier_unit. A scoreboard predicts
// each pixel's class and color from its own copy of the limit registers and
// compares every result transfer, field by field, in order. Directed edge
// pixels come first. Random pixel segments follow, each with its own limit
// setting and one of four mixes of sender gaps and result stalls.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [2:0] REG_SPARE = 3'd7;  // unmapped index, writes are dropped
	localparam int SEGMENTS       = 8;
	localparam int ITEMS_PER_SEG  = 100;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 120;
	localparam int WATCHDOG_LIMIT = 3000;

	// Gray, primaries, channel ties, negative hue and the exact limit boundaries.
	localparam logic [23:0] EDGE_PIXELS [0:17] = '{
		24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
		24'hC8C864, 24'h64C8C8, 24'hC864C8, 24'hFF000A, 24'hB4826E,
		24'h646464, 24'hFAFAFA, 24'h00AAFF, 24'h010203, 24'hFEFDFC,
		24'h80FF7F, 24'h55AA55, 24'hC8783C
	};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       skin;
	} pixel_result_t;

	class skin_scoreboard;
		int hue_low, hue_high, cb_min, cb_max, cr_min, cr_max, luma_floor;
		pixel_result_t expected_pixels[$];
		int failures, checked, skin_seen;

		function new();
			hue_low    = spc_pkg::HUE_LOW_RESET;
			hue_high   = spc_pkg::HUE_HIGH_RESET;
			cb_min     = spc_pkg::CB_LOWER_RESET;
			cb_max     = spc_pkg::CB_UPPER_RESET;
			cr_min     = spc_pkg::CR_LOWER_RESET;
			cr_max     = spc_pkg::CR_UPPER_RESET;
			luma_floor = spc_pkg::LUMA_MIN_RESET;
			failures   = 0;
			checked    = 0;
			skin_seen  = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [8:0] data);
			case (idx)
				spc_pkg::REG_HUE_LOW:  hue_low = int'(data);
				spc_pkg::REG_HUE_HIGH: hue_high = int'(data);
				spc_pkg::REG_CB_LOWER: cb_min = int'($signed(data));
				spc_pkg::REG_CB_UPPER: cb_max = int'($signed(data));
				spc_pkg::REG_CR_LOWER: cr_min = int'($signed(data));
				spc_pkg::REG_CR_UPPER: cr_max = int'($signed(data));
				spc_pkg::REG_LUMA_MIN: luma_floor = int'(data[7:0]);
				default: ;
			endcase
		endfunction

		function pixel_result_t classify_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			pixel_result_t res;
			int rv, gv, bv, luma, cb, cr, hi, lo, hue;
			bit skin;
			rv = int'(r);
			gv = int'(g);
			bv = int'(b);
			luma = 299 * rv + 587 * gv + 114 * bv;
			cb = -172 * rv - 399 * gv + 511 * bv;
			cr = 511 * rv - 428 * gv - 83 * bv;
			hi = rv;
			lo = rv;
			if (gv > hi) hi = gv;
			if (bv > hi) hi = bv;
			if (gv < lo) lo = gv;
			if (bv < lo) lo = bv;
			// Ties resolve to red first, then green; division truncates toward zero.
			if (hi == lo)
				hue = 0;
			else if (hi == rv)
				hue = (60 * (gv - bv)) / (hi - lo);
			else if (hi == gv)
				hue = (60 * (bv - rv)) / (hi - lo) + 120;
			else
				hue = (60 * (rv - gv)) / (hi - lo) + 240;
			if (hue < 0) hue += 360;
			skin = (hue < hue_low || hue > hue_high)
				&& cb > cb_min * 1000 && cb < cb_max * 1000
				&& cr > cr_min * 1000 && cr < cr_max * 1000
				&& luma > luma_floor * 1000;
			res.red   = skin ? r : spc_pkg::WHITE_LEVEL;
			res.green = skin ? g : spc_pkg::WHITE_LEVEL;
			res.blue  = skin ? b : spc_pkg::WHITE_LEVEL;
			res.skin  = skin;
			return res;
		endfunction

		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			expected_pixels.push_back(classify_pixel(r, g, b));
		endfunction

		function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic skin);
			pixel_result_t want;
			if (expected_pixels.size() == 0) begin
				$error("result (%0d,%0d,%0d) arrived with no pixel outstanding", r, g, b);
				failures++;
				return;
			end
			want = expected_pixels.pop_front();
			checked++;
			if (want.skin) skin_seen++;
			if (r !== want.red) begin
				$error("out_red: expected %0d, got %0d", want.red, r);
				failures++;
			end
			if (g !== want.green) begin
				$error("out_green: expected %0d, got %0d", want.green, g);
				failures++;
			end
			if (b !== want.blue) begin
				$error("out_blue: expected %0d, got %0d", want.blue, b);
				failures++;
			end
			if (skin !== want.skin) begin
				$error("is_skin: expected %0d, got %0d", want.skin, skin);
				failures++;
			end
		endfunction

		function void finish_check();
			if (expected_pixels.size() != 0) begin
				$error("%0d results never arrived", expected_pixels.size());
				failures++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       pixel_valid;
	logic       pixel_stall;
	logic [7:0] pixel_red;
	logic [7:0] pixel_green;
	logic [7:0] pixel_blue;
	logic       result_valid;
	logic       result_stall;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       is_skin;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [8:0] cfg_data;

	skin_scoreboard board = new();
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_request = 1'b0;
	int  stuck_cycles = 0;
	int  limit_settings = 1;

	skin_pixel_classifier_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_red    (pixel_red),
		.pixel_green  (pixel_green),
		.pixel_blue   (pixel_blue),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.is_skin      (is_skin),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_pixel(input logic [23:0] rgb);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		{pixel_red, pixel_green, pixel_blue} <= rgb;
		do @(posedge clk); while (pixel_stall);
		board.note_pixel(rgb[23:16], rgb[15:8], rgb[7:0]);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		pixel_valid <= 1'b0;
		while (board.expected_pixels.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [8:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.write_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic program_limits(input int hl, input int hh, input int cbl, input int cbu,
			input int crl, input int cru, input int luma);
		write_reg(spc_pkg::REG_HUE_LOW, 9'(hl));
		write_reg(spc_pkg::REG_HUE_HIGH, 9'(hh));
		write_reg(spc_pkg::REG_CB_LOWER, 9'(cbl));
		write_reg(spc_pkg::REG_CB_UPPER, 9'(cbu));
		write_reg(spc_pkg::REG_CR_LOWER, 9'(crl));
		write_reg(spc_pkg::REG_CR_UPPER, 9'(cru));
		write_reg(spc_pkg::REG_LUMA_MIN, 9'(luma));
		write_reg(REG_SPARE, 9'($urandom));
		cfg_we <= 1'b0;
		limit_settings++;
	endtask

	// Half the pixels are warm tones with red >= green >= blue, so that the
	// color limits decide; the rest are gray, tied channels or uniform noise.
	function automatic logic [23:0] pick_pixel();
		int kind, r, g, b;
		kind = $urandom_range(0, 9);
		r = $urandom_range(0, 255);
		g = $urandom_range(0, 255);
		b = $urandom_range(0, 255);
		if (kind < 5) begin
			r = $urandom_range(90, 255);
			g = r - int'($urandom_range(0, 90));
			if (g < 0) g = 0;
			b = g - int'($urandom_range(0, 60));
			if (b < 0) b = 0;
		end else if (kind == 5) begin
			g = r;
			b = r;
		end else if (kind == 6) begin
			case ($urandom_range(0, 2))
				0: g = r;
				1: b = g;
				default: b = r;
			endcase
		end
		return {8'(r), 8'(g), 8'(b)};
	endfunction

	initial begin : receiver
		int held;
		bit hold_done;
		hold_done = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				result_stall <= 1'b1;
				for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
			end else begin
				result_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_result(out_red, out_green, out_blue, is_skin);
	end

	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int seg, n;
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel_red = 8'd0;
		pixel_green = 8'd0;
		pixel_blue = 8'd0;
		cfg_we = 1'b0;
		cfg_index = spc_pkg::REG_HUE_LOW;
		cfg_data = 9'd0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (EDGE_PIXELS[i]) send_pixel(EDGE_PIXELS[i]);
		wait_for_results();

		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: ;
				// Every limit wide open.
				1: program_limits(360, 360, -146, 131, -131, 131, 0);
				// Every limit shut: hue band covering every hue, inverted color windows, top luma.
				2: program_limits(0, 360, 131, -146, 131, -131, 255);
				default: program_limits($urandom_range(0, 360), $urandom_range(0, 360),
						int'($urandom_range(0, 96)) - 146, int'($urandom_range(0, 146)) - 15,
						int'($urandom_range(0, 141)) - 131, int'($urandom_range(0, 101)) + 30,
						$urandom_range(0, 200));
			endcase
			case (seg % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 46; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 46; end
				default: begin send_idle_pct = 36; stall_pct = 36; end
			endcase
			// A long result hold while pixels keep coming fills the pipeline.
			if (seg == 4) hold_request = 1'b1;
			for (n = 0; n < ITEMS_PER_SEG; n++) begin
				send_pixel(pick_pixel());
				if (n == ITEMS_PER_SEG / 2) wait_for_results();
			end
			wait_for_results();
		end

		board.finish_check();
		$display("Checked %0d pixel results, %0d of them skin, under %0d limit settings.",
			board.checked, board.skin_seen, limit_settings);
		$display("Handshake mixes: free flow, sender gaps, result stalls, both, long hold.");
		if (board.failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
